FILE: rtl/wall_distance_pose_correction_top_assert.svh
// assertion macros for the wall distance pose correction block
`ifndef WALL_DISTANCE_POSE_CORRECTION_TOP_ASSERT_SVH
`define WALL_DISTANCE_POSE_CORRECTION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WDPC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("wdpc check failed");
`define WDPC_ASSERT_RESET(label, prop) \
	label: assert property (@(posedge clk) prop) else $error("wdpc reset check failed");
`else
`define WDPC_ASSERT(label, prop)
`define WDPC_ASSERT_RESET(label, prop)
`endif
`endif

FILE: rtl/wdpc_pkg.sv
// shared constants, types and tables for the wall distance pose correction block
package wdpc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int POS_FRAC = 10;
	localparam int NLANE = 4;
	localparam int LANE_FRONT = 0;
	localparam int LANE_RIGHT = 1;
	localparam int LANE_BACK = 2;
	localparam int LANE_LEFT = 3;

	localparam int DATA_W = 32;
	localparam int AW = 5;
	localparam int RNG_W = 16;
	localparam int POS_W = 19;
	localparam int CFG_W = 18;
	localparam int OFF_W = 16;
	localparam int HEAD_W = 16;

	// cordic datapath, q30 values with headroom
	localparam int CW = 34;
	localparam int QSH = 30;
	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);
	localparam int AD_W = 31;
	localparam logic [AD_W-1:0] COS_GATE = AD_W'(64'd1052266988);
	localparam logic [30:0] ATAN_TAB [24] = '{
		31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
		31'd42667331, 31'd21354465, 31'd10679838, 31'd5340245,
		31'd2670163, 31'd1335087, 31'd667544, 31'd333772,
		31'd166886, 31'd83443, 31'd41722, 31'd20861,
		31'd10430, 31'd5215, 31'd2608, 31'd1304,
		31'd652, 31'd326, 31'd163, 31'd81
	};

	// mm to position units: dist = floor((raw * 5 * 2^F + 63) / 127)
	localparam int NW = RNG_W + 3 + POS_FRAC;
	localparam int DIV_SH = NW + 7;
	localparam int MW = DIV_SH - 6;
	localparam longint DIV_M_VAL = ((64'sd1 <<< DIV_SH) + 126) / 127;
	localparam logic [MW-1:0] DIV_M = MW'(DIV_M_VAL);
	localparam int DW = NW - 6;
	localparam logic [NW-1:0] DIST_MUL = NW'(5 << POS_FRAC);
	localparam logic [NW-1:0] DIST_BIAS = NW'(63);
	localparam logic [NW-1:0] RANGE_DIV = NW'(127);
	localparam logic [RNG_W-1:0] RAW_MIN = RNG_W'(51);

	// rotated mount offset and projection widths
	localparam int PW = OFF_W + CW;
	localparam int OW = PW + 1 - QSH;
	localparam logic signed [PW:0] ROUND_OFF = (PW+1)'(64'sd1 <<< (QSH-1));
	localparam int PJ_W = DW + AD_W;
	localparam logic [PJ_W-1:0] ROUND_PJ = PJ_W'(64'd1 << (QSH-1));
	localparam int PR_W = PJ_W - QSH;
	localparam int EW0 = (PR_W + 1 > OW + 1) ? PR_W + 1 : OW + 1;
	localparam int EW = ((EW0 > CFG_W) ? EW0 : CFG_W) + 2;
	localparam logic signed [EW:0] PAIR_LIM = (EW+1)'(64'sd4 <<< POS_FRAC);
	localparam logic signed [EW-1:0] POS_MAX = EW'((64'sd1 <<< (POS_W-1)) - 1);
	localparam logic signed [EW-1:0] POS_MIN = EW'(-(64'sd1 <<< (POS_W-1)));

	localparam int NST = CORDIC_STEPS + 6;

	// register map
	localparam logic [2:0] REG_FIELD_W = 3'd0;
	localparam logic [2:0] REG_FIELD_H = 3'd1;
	localparam logic [2:0] REG_MAX_RANGE = 3'd2;
	localparam logic [2:0] REG_MAX_CORR = 3'd3;
	localparam logic [2:0] REG_FRONT_MOUNT = 3'd4;
	localparam logic [2:0] REG_BACK_MOUNT = 3'd5;
	localparam logic [2:0] REG_LEFT_MOUNT = 3'd6;
	localparam logic [2:0] REG_RIGHT_MOUNT = 3'd7;
	localparam logic [CFG_W-1:0] FIELD_RESET = CFG_W'(147456);

	typedef struct packed {
		logic signed [POS_W-1:0] pose_x;
		logic signed [POS_W-1:0] pose_y;
		logic [NLANE-1:0][RNG_W-1:0] rng;
		logic [NLANE-1:0] mask;
		logic apply;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] field_w;
		logic [CFG_W-1:0] field_h;
		logic [CFG_W-1:0] max_range;
		logic [CFG_W-1:0] max_corr;
		logic [NLANE-1:0][DATA_W-1:0] mount;
	} cfg_t;

endpackage

FILE: rtl/wdpc_if.sv
// input and result channel interfaces
interface wdpc_in_if;
	logic valid;
	logic ready;
	logic [15:0] heading;
	logic signed [18:0] pose_x;
	logic signed [18:0] pose_y;
	logic [15:0] range_front;
	logic [15:0] range_right;
	logic [15:0] range_back;
	logic [15:0] range_left;
	logic [3:0] sensor_ok_mask;
	logic apply_request;

	modport source (output valid, heading, pose_x, pose_y, range_front, range_right,
		range_back, range_left, sensor_ok_mask, apply_request, input ready);
	modport sink (input valid, heading, pose_x, pose_y, range_front, range_right,
		range_back, range_left, sensor_ok_mask, apply_request, output ready);
endinterface

interface wdpc_out_if;
	logic valid;
	logic ready;
	logic signed [18:0] new_x;
	logic signed [18:0] new_y;
	logic x_corrected;
	logic y_corrected;
	logic pose_written;

	modport source (output valid, new_x, new_y, x_corrected, y_corrected, pose_written,
		input ready);
	modport sink (input valid, new_x, new_y, x_corrected, y_corrected, pose_written,
		output ready);
endinterface

FILE: rtl/wdpc_regs.sv
// apb configuration registers
module wdpc_regs import wdpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [AW-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	logic [2:0] idx;
	logic wr;
	cfg_t cfg_q;

	assign idx = paddr[AW-1:2];
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_w <= FIELD_RESET;
			cfg_q.field_h <= FIELD_RESET;
			cfg_q.max_range <= '0;
			cfg_q.max_corr <= '0;
			cfg_q.mount <= '0;
		end else if (wr) begin
			case (idx)
				REG_FIELD_W: cfg_q.field_w <= pwdata[CFG_W-1:0];
				REG_FIELD_H: cfg_q.field_h <= pwdata[CFG_W-1:0];
				REG_MAX_RANGE: cfg_q.max_range <= pwdata[CFG_W-1:0];
				REG_MAX_CORR: cfg_q.max_corr <= pwdata[CFG_W-1:0];
				REG_FRONT_MOUNT: cfg_q.mount[LANE_FRONT] <= pwdata;
				REG_BACK_MOUNT: cfg_q.mount[LANE_BACK] <= pwdata;
				REG_LEFT_MOUNT: cfg_q.mount[LANE_LEFT] <= pwdata;
				REG_RIGHT_MOUNT: cfg_q.mount[LANE_RIGHT] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FIELD_W: prdata = DATA_W'(cfg_q.field_w);
			REG_FIELD_H: prdata = DATA_W'(cfg_q.field_h);
			REG_MAX_RANGE: prdata = DATA_W'(cfg_q.max_range);
			REG_MAX_CORR: prdata = DATA_W'(cfg_q.max_corr);
			REG_FRONT_MOUNT: prdata = cfg_q.mount[LANE_FRONT];
			REG_BACK_MOUNT: prdata = cfg_q.mount[LANE_BACK];
			REG_LEFT_MOUNT: prdata = cfg_q.mount[LANE_LEFT];
			REG_RIGHT_MOUNT: prdata = cfg_q.mount[LANE_RIGHT];
			default: prdata = '0;
		endcase
	end

endmodule

FILE: rtl/wdpc_cordic.sv
// pipelined rotation cordic, one step per stage, carries the item alongside
module wdpc_cordic import wdpc_pkg::*; (
	input logic clk,
	input logic [CORDIC_STEPS-1:0] en,
	input logic [HEAD_W-1:0] heading,
	input item_t side_in,
	output logic signed [CW-1:0] sine,
	output logic signed [CW-1:0] cosine,
	output item_t side_out
);

	logic [31:0] ang;
	logic [31:0] ang_f;
	logic flip;

	logic signed [CW-1:0] x_s [CORDIC_STEPS];
	logic signed [CW-1:0] y_s [CORDIC_STEPS];
	logic signed [CW-1:0] z_s [CORDIC_STEPS];
	logic [CORDIC_STEPS-1:0] flip_s;
	item_t side_s [CORDIC_STEPS];

	logic signed [CW-1:0] x_n [CORDIC_STEPS];
	logic signed [CW-1:0] y_n [CORDIC_STEPS];
	logic signed [CW-1:0] z_n [CORDIC_STEPS];

	// fold into [-90, 90) degrees, negate results at the end when folded
	assign ang = {heading, 16'h0000};
	assign flip = (ang - 32'h4000_0000) < 32'h8000_0000;
	assign ang_f = flip ? ang - 32'h8000_0000 : ang;

	always_comb begin
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [CW-1:0] zi;
		logic signed [CW-1:0] at;
		for (int j = 0; j < CORDIC_STEPS; j++) begin
			if (j == 0) begin
				xi = CORDIC_GAIN;
				yi = '0;
				zi = CW'($signed(ang_f));
			end else begin
				xi = x_s[j-1];
				yi = y_s[j-1];
				zi = z_s[j-1];
			end
			at = CW'(ATAN_TAB[j]);
			if (!zi[CW-1]) begin
				x_n[j] = xi - (yi >>> j);
				y_n[j] = yi + (xi >>> j);
				z_n[j] = zi - at;
			end else begin
				x_n[j] = xi + (yi >>> j);
				y_n[j] = yi - (xi >>> j);
				z_n[j] = zi + at;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < CORDIC_STEPS; j++) begin
			if (en[j]) begin
				x_s[j] <= x_n[j];
				y_s[j] <= y_n[j];
				z_s[j] <= z_n[j];
				if (j == 0) begin
					flip_s[j] <= flip;
					side_s[j] <= side_in;
				end else begin
					flip_s[j] <= flip_s[j-1];
					side_s[j] <= side_s[j-1];
				end
			end
		end
	end

	assign cosine = flip_s[CORDIC_STEPS-1] ? -x_s[CORDIC_STEPS-1] : x_s[CORDIC_STEPS-1];
	assign sine = flip_s[CORDIC_STEPS-1] ? -y_s[CORDIC_STEPS-1] : y_s[CORDIC_STEPS-1];
	assign side_out = side_s[CORDIC_STEPS-1];

endmodule

FILE: rtl/wall_distance_pose_correction_top.sv
// wall distance pose correction top: cordic, four range lanes, per-axis settle
// pipeline: 16 cordic stages + 6 lane stages from input beat to result beat
// throughput: one beat per cycle while results are taken; a full stage holds its beat when the next one cannot advance
// empty stages let input beats keep entering while a result waits in the result register at the end
// reset clears all stage valid bits and loads the register defaults
`include "wall_distance_pose_correction_top_assert.svh"
module wall_distance_pose_correction_top import wdpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	wdpc_in_if.sink pose_in,
	wdpc_out_if.source pose_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [AW-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	localparam int P1 = CORDIC_STEPS;
	localparam int P2 = CORDIC_STEPS + 1;
	localparam int P3 = CORDIC_STEPS + 2;
	localparam int P4 = CORDIC_STEPS + 3;
	localparam int P5 = CORDIC_STEPS + 4;
	localparam int P6 = CORDIC_STEPS + 5;

	typedef struct packed {
		logic ok;
		logic signed [EW-1:0] mean;
	} settle_t;

	// pick first two estimates, drop axis on any jump or pair spread, then average
	function automatic settle_t settle(input logic [NLANE-1:0][EW-1:0] est,
		input logic [NLANE-1:0] use_e, input logic signed [POS_W-1:0] cur,
		input logic [CFG_W-1:0] lim);
		settle_t r;
		logic signed [EW-1:0] e0;
		logic signed [EW-1:0] e1;
		logic signed [EW-1:0] cur2;
		logic signed [EW:0] d;
		logic signed [EW:0] lim2;
		logic signed [EW:0] sum;
		logic [1:0] cnt;
		logic rej;
		e0 = '0;
		e1 = '0;
		cnt = '0;
		rej = 1'b0;
		cur2 = EW'(cur) <<< 1;
		lim2 = $signed({1'b0, EW'({lim, 1'b0})});
		for (int k = 0; k < NLANE; k++) begin
			if (use_e[k]) begin
				d = (EW+1)'(signed'(est[k])) - (EW+1)'(cur2);
				if (d < 0) d = -d;
				if (d > lim2) rej = 1'b1;
				if (cnt == 2'd0) e0 = signed'(est[k]);
				else if (cnt == 2'd1) e1 = signed'(est[k]);
				if (cnt != 2'd2) cnt = cnt + 2'd1;
			end
		end
		d = (EW+1)'(e0) - (EW+1)'(e1);
		if (d < 0) d = -d;
		if (cnt == 2'd2 && d > PAIR_LIM) rej = 1'b1;
		if (cnt == 2'd2) sum = ((EW+1)'(e0) + (EW+1)'(e1) + (EW+1)'(2)) >>> 2;
		else sum = ((EW+1)'(e0) + (EW+1)'(1)) >>> 1;
		r.mean = EW'(sum);
		r.ok = (cnt != 2'd0) && !rej;
		return r;
	endfunction

	cfg_t cfg;
	logic cfg_ok;

	// stage valid bits and per-stage advance
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	item_t side_in;
	item_t cside;
	logic signed [CW-1:0] sine;
	logic signed [CW-1:0] cosine;

	wdpc_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign cfg_ok = (cfg.field_w != '0) && (cfg.field_h != '0) && (cfg.max_corr != '0);

	always_comb begin
		en[NST-1] = !vld_q[NST-1] || pose_out.ready;
		for (int i = NST - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= pose_in.valid;
			for (int i = 1; i < NST; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign pose_in.ready = en[0];

	always_comb begin
		side_in.pose_x = pose_in.pose_x;
		side_in.pose_y = pose_in.pose_y;
		side_in.rng[LANE_FRONT] = pose_in.range_front;
		side_in.rng[LANE_RIGHT] = pose_in.range_right;
		side_in.rng[LANE_BACK] = pose_in.range_back;
		side_in.rng[LANE_LEFT] = pose_in.range_left;
		side_in.mask = pose_in.sensor_ok_mask;
		side_in.apply = pose_in.apply_request;
	end

	wdpc_cordic u_cordic (
		.clk(clk),
		.en(en[CORDIC_STEPS-1:0]),
		.heading(pose_in.heading),
		.side_in(side_in),
		.sine(sine),
		.cosine(cosine),
		.side_out(cside)
	);

	// stage 1: reading gate, reciprocal multiply, mount offset products
	logic signed [CW-1:0] s_s1;
	logic signed [CW-1:0] c_s1;
	logic [NLANE-1:0] ok_s1;
	logic [NW+MW-1:0] nmul_s1 [NLANE];
	logic signed [PW-1:0] pxc_s1 [NLANE];
	logic signed [PW-1:0] pys_s1 [NLANE];
	logic signed [PW-1:0] pyc_s1 [NLANE];
	logic signed [PW-1:0] pxs_s1 [NLANE];
	logic signed [POS_W-1:0] px_s1, py_s1;
	logic apl_s1;

	logic [NLANE-1:0] ok_n;
	logic [NW-1:0] scaled_n [NLANE];
	logic signed [OFF_W-1:0] offx_n [NLANE];
	logic signed [OFF_W-1:0] offy_n [NLANE];
	logic [NW-1:0] lim_r;

	always_comb begin
		lim_r = NW'(cfg.max_range) * RANGE_DIV;
		for (int k = 0; k < NLANE; k++) begin
			scaled_n[k] = NW'(cside.rng[k]) * DIST_MUL;
			ok_n[k] = cside.mask[k] && (cside.rng[k] >= RAW_MIN) && !(scaled_n[k] > lim_r);
			offx_n[k] = signed'(cfg.mount[k][OFF_W-1:0]);
			offy_n[k] = signed'(cfg.mount[k][2*OFF_W-1:OFF_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[P1]) begin
			s_s1 <= sine;
			c_s1 <= cosine;
			ok_s1 <= ok_n;
			px_s1 <= cside.pose_x;
			py_s1 <= cside.pose_y;
			apl_s1 <= cside.apply;
			for (int k = 0; k < NLANE; k++) begin
				nmul_s1[k] <= (NW+MW)'(scaled_n[k] + DIST_BIAS) * (NW+MW)'(DIV_M);
				pxc_s1[k] <= offx_n[k] * cosine;
				pys_s1[k] <= offy_n[k] * sine;
				pyc_s1[k] <= offy_n[k] * cosine;
				pxs_s1[k] <= offx_n[k] * sine;
			end
		end
	end

	// stage 2: distance, rotated offset, axis gates and beam signs
	logic [DW-1:0] dist_s2 [NLANE];
	logic signed [OW-1:0] ox_s2 [NLANE];
	logic signed [OW-1:0] oy_s2 [NLANE];
	logic [AD_W-1:0] as_s2, ac_s2;
	logic [NLANE-1:0] gx_s2, gy_s2, xp_s2, yp_s2;
	logic signed [POS_W-1:0] px_s2, py_s2;
	logic apl_s2;

	logic [AD_W-1:0] as_n, ac_n;
	logic s_neg, c_neg;
	logic [NLANE-1:0] gx_n, gy_n, xp_n, yp_n;

	always_comb begin
		logic even;
		logic bx;
		logic by;
		s_neg = s_s1[CW-1];
		c_neg = c_s1[CW-1];
		as_n = AD_W'(s_neg ? -s_s1 : s_s1);
		ac_n = AD_W'(c_neg ? -c_s1 : c_s1);
		for (int k = 0; k < NLANE; k++) begin
			even = (k % 2) == 0;
			// x beam: front s, right c, back -s, left -c
			bx = even ? s_neg : c_neg;
			xp_n[k] = (k < 2) ? !bx : bx;
			gx_n[k] = ok_s1[k] && ((even ? as_n : ac_n) >= COS_GATE);
			// y beam: front c, right -s, back -c, left s
			by = even ? c_neg : s_neg;
			yp_n[k] = (k == LANE_FRONT || k == LANE_LEFT) ? !by : by;
			gy_n[k] = ok_s1[k] && ((even ? ac_n : as_n) >= COS_GATE);
		end
	end

	always_ff @(posedge clk) begin
		if (en[P2]) begin
			as_s2 <= as_n;
			ac_s2 <= ac_n;
			gx_s2 <= gx_n;
			gy_s2 <= gy_n;
			xp_s2 <= xp_n;
			yp_s2 <= yp_n;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			apl_s2 <= apl_s1;
			for (int k = 0; k < NLANE; k++) begin
				dist_s2[k] <= nmul_s1[k][DIV_SH +: DW];
				ox_s2[k] <= OW'(((PW+1)'(pxc_s1[k]) + (PW+1)'(pys_s1[k]) + ROUND_OFF) >>> QSH);
				oy_s2[k] <= OW'(((PW+1)'(pyc_s1[k]) - (PW+1)'(pxs_s1[k]) + ROUND_OFF) >>> QSH);
			end
		end
	end

	// stage 3: projection products
	logic [PJ_W-1:0] pjx_s3 [NLANE];
	logic [PJ_W-1:0] pjy_s3 [NLANE];
	logic signed [OW-1:0] ox_s3 [NLANE];
	logic signed [OW-1:0] oy_s3 [NLANE];
	logic [NLANE-1:0] gx_s3, gy_s3, xp_s3, yp_s3;
	logic signed [POS_W-1:0] px_s3, py_s3;
	logic apl_s3;

	always_ff @(posedge clk) begin
		if (en[P3]) begin
			gx_s3 <= gx_s2;
			gy_s3 <= gy_s2;
			xp_s3 <= xp_s2;
			yp_s3 <= yp_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			apl_s3 <= apl_s2;
			for (int k = 0; k < NLANE; k++) begin
				pjx_s3[k] <= PJ_W'(dist_s2[k]) * PJ_W'((k % 2) == 0 ? as_s2 : ac_s2);
				pjy_s3[k] <= PJ_W'(dist_s2[k]) * PJ_W'((k % 2) == 0 ? ac_s2 : as_s2);
				ox_s3[k] <= ox_s2[k];
				oy_s3[k] <= oy_s2[k];
			end
		end
	end

	// stage 4: wall estimates at twice the scale
	logic [NLANE-1:0][EW-1:0] ex_s4, ey_s4;
	logic [NLANE-1:0] gx_s4, gy_s4;
	logic signed [POS_W-1:0] px_s4, py_s4;
	logic apl_s4;

	logic [NLANE-1:0][EW-1:0] ex_n, ey_n;

	always_comb begin
		logic [PR_W-1:0] prx;
		logic [PR_W-1:0] pry;
		logic signed [EW-1:0] szx;
		logic signed [EW-1:0] szy;
		logic signed [EW-1:0] tpx;
		logic signed [EW-1:0] tpy;
		logic signed [EW-1:0] tox;
		logic signed [EW-1:0] toy;
		szx = EW'($signed({1'b0, cfg.field_w}));
		szy = EW'($signed({1'b0, cfg.field_h}));
		for (int k = 0; k < NLANE; k++) begin
			prx = PR_W'((pjx_s3[k] + ROUND_PJ) >> QSH);
			pry = PR_W'((pjy_s3[k] + ROUND_PJ) >> QSH);
			tpx = EW'($signed({1'b0, prx, 1'b0}));
			tpy = EW'($signed({1'b0, pry, 1'b0}));
			tox = EW'(ox_s3[k]) <<< 1;
			toy = EW'(oy_s3[k]) <<< 1;
			ex_n[k] = xp_s3[k] ? szx - tpx - tox : tpx - szx - tox;
			ey_n[k] = yp_s3[k] ? szy - tpy - toy : tpy - szy - toy;
		end
	end

	always_ff @(posedge clk) begin
		if (en[P4]) begin
			ex_s4 <= ex_n;
			ey_s4 <= ey_n;
			gx_s4 <= gx_s3;
			gy_s4 <= gy_s3;
			px_s4 <= px_s3;
			py_s4 <= py_s3;
			apl_s4 <= apl_s3;
		end
	end

	// stage 5: per-axis acceptance and mean
	settle_t sx_s5, sy_s5;
	logic signed [POS_W-1:0] px_s5, py_s5;
	logic apl_s5;

	always_ff @(posedge clk) begin
		if (en[P5]) begin
			sx_s5 <= settle(ex_s4, gx_s4, px_s4, cfg.max_corr);
			sy_s5 <= settle(ey_s4, gy_s4, py_s4, cfg.max_corr);
			px_s5 <= px_s4;
			py_s5 <= py_s4;
			apl_s5 <= apl_s4;
		end
	end

	// stage 6: saturate, fall back to the current pose, result register
	logic signed [POS_W-1:0] nx_s6, ny_s6;
	logic xc_s6, yc_s6, pw_s6;

	logic xc_n, yc_n;
	logic signed [POS_W-1:0] mx_n, my_n;

	always_comb begin
		xc_n = cfg_ok && sx_s5.ok;
		yc_n = cfg_ok && sy_s5.ok;
		if (sx_s5.mean > POS_MAX) mx_n = POS_W'(POS_MAX);
		else if (sx_s5.mean < POS_MIN) mx_n = POS_W'(POS_MIN);
		else mx_n = POS_W'(sx_s5.mean);
		if (sy_s5.mean > POS_MAX) my_n = POS_W'(POS_MAX);
		else if (sy_s5.mean < POS_MIN) my_n = POS_W'(POS_MIN);
		else my_n = POS_W'(sy_s5.mean);
	end

	always_ff @(posedge clk) begin
		if (en[P6]) begin
			nx_s6 <= xc_n ? mx_n : px_s5;
			ny_s6 <= yc_n ? my_n : py_s5;
			xc_s6 <= xc_n;
			yc_s6 <= yc_n;
			pw_s6 <= apl_s5 && (xc_n || yc_n);
		end
	end

	assign pose_out.valid = vld_q[NST-1];
	assign pose_out.new_x = nx_s6;
	assign pose_out.new_y = ny_s6;
	assign pose_out.x_corrected = xc_s6;
	assign pose_out.y_corrected = yc_s6;
	assign pose_out.pose_written = pw_s6;

	`WDPC_ASSERT(a_written_needs_fix, pose_out.valid |-> (!pose_out.pose_written || pose_out.x_corrected || pose_out.y_corrected))
	`WDPC_ASSERT(a_stall_from_output, !pose_in.ready |-> (pose_out.valid && !pose_out.ready))
	`WDPC_ASSERT(a_accept_enters, (pose_in.valid && pose_in.ready) |=> vld_q[0])
	`WDPC_ASSERT_RESET(a_reset_empty, !arst_n |=> !pose_out.valid)

endmodule

FILE: tb/tb_top.sv
// testbench for wall_distance_pose_correction_top: predictor-checked pose beats and apb setup
module tb_top;
	import wdpc_pkg::*;

	localparam string PASS_MSG = "** wall_distance_pose_correction_top: PASSED **";
	localparam string FAIL_MSG = "** wall_distance_pose_correction_top: FAILED **";
	localparam longint COS_MIN = 64'd1052266988;
	localparam longint GAIN0 = 64'd652032874;
	localparam longint HALF30 = 64'd536870912;
	localparam int N_RANDOM = 950;

	// one input beat, lanes front, right, back, left
	typedef struct {
		logic [15:0] heading;
		logic signed [18:0] px;
		logic signed [18:0] py;
		logic [15:0] rf, rr, rb, rl;
		logic [3:0] mask;
		logic apply;
	} pose_beat_t;

	// one corrected pose beat
	typedef struct {
		logic signed [18:0] nx;
		logic signed [18:0] ny;
		logic xc;
		logic yc;
		logic pw;
	} pose_fix_t;

	typedef struct {
		pose_beat_t b;
		bit typed;
		pose_fix_t r;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [AW-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	wdpc_in_if pose_in();
	wdpc_out_if pose_out();

	wall_distance_pose_correction_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pose_in(pose_in.sink),
		.pose_out(pose_out.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// shadow copy of the register file, mounts kept in lane order
	longint field_w_q, field_h_q, max_range_q, max_corr_q;
	logic [31:0] mount_q [4];

	pose_fix_t fix_q[$];
	int n_bad;
	bit quiet;

	longint atan_q30 [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	// while the block holds reset defaults max_correction is zero, so poses pass through
	stim_row_t pass_tab [8] = '{
		'{'{16'h0000, 19'sd0, 19'sd0, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 4'hf, 1'b1},
			1'b1, '{19'sd0, 19'sd0, 1'b0, 1'b0, 1'b0}},
		'{'{16'hffff, 19'sd262143, -19'sd262144, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			4'hf, 1'b1}, 1'b1, '{19'sd262143, -19'sd262144, 1'b0, 1'b0, 1'b0}},
		'{'{16'h8000, -19'sd262144, 19'sd262143, 16'd0, 16'd0, 16'd0, 16'd0, 4'h0, 1'b0},
			1'b1, '{-19'sd262144, 19'sd262143, 1'b0, 1'b0, 1'b0}},
		'{'{16'h4000, 19'sd1, -19'sd1, 16'd50, 16'd51, 16'd50, 16'd51, 4'h5, 1'b1},
			1'b1, '{19'sd1, -19'sd1, 1'b0, 1'b0, 1'b0}},
		'{'{16'hc000, 19'sd12345, 19'sd54321, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
			4'ha, 1'b0}, 1'b1, '{19'sd12345, 19'sd54321, 1'b0, 1'b0, 1'b0}},
		'{'{16'h2000, -19'sd4096, 19'sd4096, 16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0,
			4'hf, 1'b1}, 1'b1, '{-19'sd4096, 19'sd4096, 1'b0, 1'b0, 1'b0}},
		'{'{16'h7fff, 19'sd0, 19'sd0, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'hf, 1'b1},
			1'b1, '{19'sd0, 19'sd0, 1'b0, 1'b0, 1'b0}},
		'{'{16'h8001, 19'sd100, 19'sd100, 16'd1, 16'd2, 16'd3, 16'd4, 4'h9, 1'b0},
			1'b1, '{19'sd100, 19'sd100, 1'b0, 1'b0, 1'b0}}
	};

	// with a valid field, checked against the predictor
	// field 147456 units = 144 in, wall at 72 in = 1829 mm from center
	stim_row_t fix_tab [14] = '{
		'{'{16'h0000, 19'sd0, 19'sd0, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'hf, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		'{'{16'h4000, 19'sd500, -19'sd700, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'hf, 1'b0},
			1'b0, '{0, 0, 0, 0, 0}},
		'{'{16'h8000, 19'sd0, 19'sd0, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'hf, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		'{'{16'hc000, 19'sd0, 19'sd0, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'hf, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		// beams at 45 degrees reach no axis
		'{'{16'h2000, 19'sd0, 19'sd0, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'hf, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		// just under and just at 2 inches
		'{'{16'h0000, 19'sd0, 19'sd0, 16'd50, 16'd51, 16'd50, 16'd51, 4'hf, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		// longest reading beyond the range limit
		'{'{16'h0000, 19'sd0, 19'sd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'hf, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		// front and back disagree by more than 2 inches
		'{'{16'h0000, 19'sd0, 19'sd0, 16'd1829, 16'd1829, 16'd1700, 16'd1829, 4'hf, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		// estimate too far from the current value
		'{'{16'h0000, 19'sd60000, 19'sd0, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'h3, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		// masked lanes
		'{'{16'h0000, 19'sd0, 19'sd0, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'h0, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		'{'{16'h0000, 19'sd0, 19'sd0, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'h6, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}},
		'{'{16'h00c0, -19'sd1000, 19'sd2000, 16'd1750, 16'd1900, 16'd1900, 16'd1750, 4'hf,
			1'b1}, 1'b0, '{0, 0, 0, 0, 0}},
		'{'{16'hff40, 19'sd262143, -19'sd262144, 16'd3000, 16'd60, 16'd60, 16'd3000, 4'hf,
			1'b1}, 1'b0, '{0, 0, 0, 0, 0}},
		'{'{16'h0e38, 19'sd0, 19'sd0, 16'd1829, 16'd1829, 16'd1829, 16'd1829, 4'hf, 1'b1},
			1'b0, '{0, 0, 0, 0, 0}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint abs_l(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// sine and cosine in q30 by folding to a half turn and rotating
	function automatic void heading_sin_cos(logic [15:0] h, output longint s, output longint c);
		logic [31:0] a;
		bit flip;
		longint x, y, z, xs, ys;
		a = {h, 16'h0000};
		flip = (32'(a - 32'h4000_0000) < 32'h8000_0000);
		if (flip) a = 32'(a - 32'h8000_0000);
		z = longint'($signed(a));
		x = GAIN0;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_q30[i];
			end else begin
				x += ys; y -= xs; z += atan_q30[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x;
		s = y;
	endfunction

	// wall position at twice scale, minus projected beam and rotated mount
	function automatic longint wall_estimate(longint d, longint reach, longint size,
		longint off);
		longint proj;
		proj = (reach * abs_l(d) + HALF30) >>> 30;
		if (d > 0) return size - 2 * proj - 2 * off;
		return -size + 2 * proj - 2 * off;
	endfunction

	function automatic longint axis_settle(longint e0, longint e1, int n, longint cur,
		output logic used);
		longint m;
		used = 1'b0;
		if (n == 0) return cur;
		if (abs_l(e0 - 2 * cur) > 2 * max_corr_q) return cur;
		if (n > 1 && abs_l(e1 - 2 * cur) > 2 * max_corr_q) return cur;
		if (n > 1 && abs_l(e0 - e1) > (longint'(4) << POS_FRAC)) return cur;
		m = (n == 1) ? ((e0 + 1) >>> 1) : ((e0 + e1 + 2) >>> 2);
		if (m > 262143) m = 262143;
		if (m < -262144) m = -262144;
		used = 1'b1;
		return m;
	endfunction

	function automatic pose_fix_t correct_pose(pose_beat_t b);
		pose_fix_t r;
		longint s, c, raw, num, reach, offx, offy, ox, oy, cx, cy;
		longint ldx [4];
		longint ldy [4];
		longint xe [4];
		longint ye [4];
		longint rng [4];
		int nxe, nye;
		logic xc, yc;
		cx = b.px;
		cy = b.py;
		xc = 1'b0;
		yc = 1'b0;
		nxe = 0;
		nye = 0;
		rng = '{b.rf, b.rr, b.rb, b.rl};
		xe = '{0, 0, 0, 0};
		ye = '{0, 0, 0, 0};
		if (field_w_q != 0 && field_h_q != 0 && max_corr_q != 0) begin
			heading_sin_cos(b.heading, s, c);
			ldx = '{s, c, -s, -c};
			ldy = '{c, -s, -c, s};
			for (int k = 0; k < 4; k++) begin
				raw = rng[k];
				num = (raw * 10) << POS_FRAC;
				if (b.mask[k] && raw * 10 >= 508 && num <= max_range_q * 254) begin
					reach = (num + 127) / 254;
					offx = longint'($signed(mount_q[k][15:0]));
					offy = longint'($signed(mount_q[k][31:16]));
					ox = (offx * c + offy * s + HALF30) >>> 30;
					oy = (offy * c - offx * s + HALF30) >>> 30;
					if (abs_l(ldx[k]) >= COS_MIN) begin
						xe[nxe] = wall_estimate(ldx[k], reach, field_w_q, ox);
						nxe++;
					end
					if (abs_l(ldy[k]) >= COS_MIN) begin
						ye[nye] = wall_estimate(ldy[k], reach, field_h_q, oy);
						nye++;
					end
				end
			end
			cx = axis_settle(xe[0], xe[1], nxe, cx, xc);
			cy = axis_settle(ye[0], ye[1], nye, cy, yc);
		end
		r.nx = cx[18:0];
		r.ny = cy[18:0];
		r.xc = xc;
		r.yc = yc;
		r.pw = b.apply & (xc | yc);
		return r;
	endfunction

	// ---------------------------------------------------------------- apb setup

	// setup then access cycle; the caller releases the bus after its last write
	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AW'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_FIELD_W: field_w_q = longint'(val[17:0]);
			REG_FIELD_H: field_h_q = longint'(val[17:0]);
			REG_MAX_RANGE: max_range_q = longint'(val[17:0]);
			REG_MAX_CORR: max_corr_q = longint'(val[17:0]);
			REG_FRONT_MOUNT: mount_q[LANE_FRONT] = val;
			REG_BACK_MOUNT: mount_q[LANE_BACK] = val;
			REG_LEFT_MOUNT: mount_q[LANE_LEFT] = val;
			REG_RIGHT_MOUNT: mount_q[LANE_RIGHT] = val;
			default: ;
		endcase
	endtask

	// each result is one beat, so an empty queue means the pipe is drained
	task automatic wait_drained();
		pose_in.valid <= 1'b0;
		while (fix_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic small_mount(logic [2:0] idx);
		cfg_write(idx, {16'($urandom_range(0, 2048) - 1024), 16'($urandom_range(0, 2048) - 1024)});
	endtask

	task automatic load_setting(int p);
		wait_drained();
		case (p)
			0, 4: begin
				// nominal field, small mounts
				cfg_write(REG_FIELD_W, 32'd147456);
				cfg_write(REG_FIELD_H, 32'd147456);
				cfg_write(REG_MAX_RANGE, 32'd262143);
				cfg_write(REG_MAX_CORR, (p == 0) ? 32'd4096 : 32'd8192);
				small_mount(REG_FRONT_MOUNT);
				small_mount(REG_BACK_MOUNT);
				small_mount(REG_LEFT_MOUNT);
				small_mount(REG_RIGHT_MOUNT);
			end
			1: begin
				// field, range and jump limit at their top, mounts at signed extremes and minus one
				cfg_write(REG_FIELD_W, 32'h3ffff);
				cfg_write(REG_FIELD_H, 32'h3ffff);
				cfg_write(REG_MAX_RANGE, 32'h3ffff);
				cfg_write(REG_MAX_CORR, 32'h3ffff);
				cfg_write(REG_FRONT_MOUNT, 32'h7fff7fff);
				cfg_write(REG_BACK_MOUNT, 32'h80008000);
				cfg_write(REG_LEFT_MOUNT, 32'hffffffff);
				cfg_write(REG_RIGHT_MOUNT, 32'h80007fff);
			end
			2: begin
				// smallest valid field and jump limit
				cfg_write(REG_FIELD_W, 32'd1);
				cfg_write(REG_FIELD_H, 32'd1);
				cfg_write(REG_MAX_RANGE, $urandom_range(0, 262143));
				cfg_write(REG_MAX_CORR, 32'd1);
				cfg_write(REG_FRONT_MOUNT, 32'h0);
				cfg_write(REG_RIGHT_MOUNT, $urandom);
			end
			default: begin
				// no range accepted, then an invalid field height
				cfg_write(REG_FIELD_W, 32'd147456);
				cfg_write(REG_FIELD_H, (p == 3) ? 32'd147456 : 32'd0);
				cfg_write(REG_MAX_RANGE, 32'd0);
				cfg_write(REG_MAX_CORR, 32'h3ffff);
			end
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// ---------------------------------------------------------------- stimulus

	// hold the beat until accepted, expectation queued at the accepting edge
	task automatic send_beat(pose_beat_t b, bit typed, pose_fix_t r);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			pose_in.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		pose_in.valid <= 1'b1;
		pose_in.heading <= b.heading;
		pose_in.pose_x <= b.px;
		pose_in.pose_y <= b.py;
		pose_in.range_front <= b.rf;
		pose_in.range_right <= b.rr;
		pose_in.range_back <= b.rb;
		pose_in.range_left <= b.rl;
		pose_in.sensor_ok_mask <= b.mask;
		pose_in.apply_request <= b.apply;
		do @(posedge clk); while (!pose_in.ready);
		fix_q.insert(fix_q.size(), typed ? r : correct_pose(b));
	endtask

	function automatic logic [15:0] wall_mm(longint units);
		longint mm;
		mm = (units * 254) / 10240 + $urandom_range(0, 4) - 2;
		if (mm < 0) mm = 0;
		if (mm > 65535) mm = 65535;
		return mm[15:0];
	endfunction

	function automatic logic signed [18:0] clip19(longint v);
		if (v > 262143) return 19'sd262143;
		if (v < -262144) return -19'sd262144;
		return v[18:0];
	endfunction

	// ranges that a robot at a true pose would read, with a nearby believed pose
	function automatic pose_beat_t plausible_beat();
		pose_beat_t b;
		longint tx, ty, hw, hh, spread;
		longint d [4];
		int card, q;
		logic [15:0] r [4];
		hw = field_w_q / 2;
		hh = field_h_q / 2;
		tx = (hw > 3000) ? longint'($urandom_range(0, 2 * (hw - 3000))) - (hw - 3000) : 0;
		ty = (hh > 3000) ? longint'($urandom_range(0, 2 * (hh - 3000))) - (hh - 3000) : 0;
		card = $urandom_range(0, 3);
		spread = ($urandom_range(0, 4) == 0) ? 2500 : 200;
		b.heading = 16'(card * 16384 + longint'($urandom_range(0, 2 * spread)) - spread);
		// beam direction per quarter: +y, +x, -y, -x
		d = '{hh - ty, hw - tx, hh + ty, hw + tx};
		for (int k = 0; k < 4; k++) begin
			q = (card + ((k == LANE_LEFT) ? 3 : k)) % 4;
			r[k] = wall_mm(d[q]);
		end
		b.rf = r[LANE_FRONT];
		b.rr = r[LANE_RIGHT];
		b.rb = r[LANE_BACK];
		b.rl = r[LANE_LEFT];
		b.px = clip19(tx + longint'($urandom_range(0, 8000)) - 4000);
		b.py = clip19(ty + longint'($urandom_range(0, 8000)) - 4000);
		b.mask = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hf;
		b.apply = 1'($urandom_range(0, 1));
		return b;
	endfunction

	function automatic pose_beat_t noise_beat();
		pose_beat_t b;
		b.heading = 16'($urandom);
		b.px = 19'($urandom);
		b.py = 19'($urandom);
		b.rf = 16'($urandom);
		b.rr = 16'($urandom);
		b.rb = 16'($urandom);
		b.rl = 16'($urandom);
		b.mask = 4'($urandom);
		b.apply = 1'($urandom);
		return b;
	endfunction

	// receiver stalls in random bursts
	initial begin
		pose_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				pose_out.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			pose_out.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		pose_fix_t e;
		if (arst_n && pose_out.valid && pose_out.ready) begin
			if (fix_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("result beat with nothing expected");
			end else begin
				e = fix_q.pop_front();
				if (pose_out.new_x !== e.nx || pose_out.new_y !== e.ny
					|| pose_out.x_corrected !== e.xc || pose_out.y_corrected !== e.yc
					|| pose_out.pose_written !== e.pw) begin
					n_bad++;
					if (n_bad <= 10)
						$display("pose mismatch: exp x=%0d y=%0d xc=%b yc=%b pw=%b, got x=%0d y=%0d xc=%b yc=%b pw=%b",
							e.nx, e.ny, e.xc, e.yc, e.pw, pose_out.new_x, pose_out.new_y,
							pose_out.x_corrected, pose_out.y_corrected, pose_out.pose_written);
				end
			end
		end
	end

	initial begin
		#5000000;
		$display(FAIL_MSG);
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		pose_fix_t none;
		int p;
		none = '{0, 0, 0, 0, 0};
		n_bad = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pose_in.valid = 1'b0;
		pose_in.heading = '0;
		pose_in.pose_x = '0;
		pose_in.pose_y = '0;
		pose_in.range_front = '0;
		pose_in.range_right = '0;
		pose_in.range_back = '0;
		pose_in.range_left = '0;
		pose_in.sensor_ok_mask = '0;
		pose_in.apply_request = 1'b0;
		field_w_q = 147456;
		field_h_q = 147456;
		max_range_q = 0;
		max_corr_q = 0;
		mount_q = '{0, 0, 0, 0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: max_correction zero, every pose passes through
		foreach (pass_tab[i]) send_beat(pass_tab[i].b, pass_tab[i].typed, pass_tab[i].r);

		load_setting(0);
		foreach (fix_tab[i]) send_beat(fix_tab[i].b, fix_tab[i].typed, fix_tab[i].r);

		// random part, settings change every 190 beats, last stretch without idling
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 190 == 0) begin
				p = n / 190;
				load_setting((p == 0) ? 4 : (p == 4) ? 0 : p);
				quiet = (p == 4);
			end
			// hold off until the pipe is empty once
			if (n == 100) wait_drained();
			if ($urandom_range(0, 9) < 7) send_beat(plausible_beat(), 1'b0, none);
			else send_beat(noise_beat(), 1'b0, none);
		end
		// invalid field height at the very end
		load_setting(5);
		for (int n = 0; n < 20; n++) send_beat(plausible_beat(), 1'b0, none);

		pose_in.valid <= 1'b0;
		while (fix_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (n_bad == 0) begin
			$display(PASS_MSG);
		end else begin
			$display(FAIL_MSG);
		end
		$finish;
	end

endmodule
